// ===== rtl/core/pmq_pkg.sv =====
`default_nettype none

package pmq_pkg;

   typedef enum logic [1:0] {
      OP_ENQUEUE = 2'd0,
      OP_DEQUEUE = 2'd1,
      OP_SIZE    = 2'd2,
      OP_REINIT  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      op_type             op;
      logic [1:0]         queue_id;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic signed [31:0] data;
      logic [7:0]         count;
   } rsp_type;

   // Selects where the response data word comes from.
   typedef enum logic [1:0] {
      DSEL_ZERO  = 2'd0,
      DSEL_EMPTY = 2'd1,
      DSEL_MEM   = 2'd2
   } dsel_type;

   localparam logic signed [31:0] EMPTY_DATA = -32'sd1;

endpackage

`default_nettype wire

// ===== rtl/core/partitioned_multi_queue_top.sv =====
`default_nettype none

// Several linear queues share one word memory that is split into equal regions, one per
// queue; the last queue also takes the remainder. The block takes one transaction in every
// clock cycle (busy is never raised) and answers each one in the cycle after it was
// accepted, with a single-cycle rsp_strobe. The pointer update and the memory write or read
// happen in the cycle of acceptance; the memory's read port is registered. The receiver
// cannot stall the block, so results must be taken as they appear. Freed slots are not reused
// until a reset or a reinitialize transaction clears all pointers.
module partitioned_multi_queue_top #(
   parameter int MEMORY_DEPTH = 128,
   parameter int QUEUE_COUNT  = 3
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   start,
   output logic                  busy,
   input  pmq_pkg::req_type      req_payload,
   output logic                  rsp_strobe,
   output pmq_pkg::rsp_type      rsp_payload
);

   localparam int AW     = (MEMORY_DEPTH > 1) ? $clog2(MEMORY_DEPTH) : 1;
   localparam int CW     = $clog2(MEMORY_DEPTH + 1);
   localparam int QW     = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;
   localparam int REGION = MEMORY_DEPTH / QUEUE_COUNT;
   localparam int LAST_SIZE = MEMORY_DEPTH - (QUEUE_COUNT - 1) * REGION;

   logic [31:0]   item_store [MEMORY_DEPTH];
   logic [31:0]   rd_data_ff;

   logic [CW-1:0] wr_cnt_ff [QUEUE_COUNT];
   logic [CW-1:0] rd_cnt_ff [QUEUE_COUNT];

   logic                  rsp_strobe_ff;
   pmq_pkg::status_type   status_ff;
   pmq_pkg::dsel_type     dsel_ff;
   logic [7:0]            count_ff;

   logic                  accept;
   logic                  in_range;
   logic [QW-1:0]         qidx;
   logic [CW-1:0]         wr_cnt;
   logic [CW-1:0]         rd_cnt;
   logic [CW-1:0]         region_size;
   logic [CW-1:0]         base;
   logic                  is_full;
   logic                  is_empty;
   logic                  do_enq;
   logic                  do_deq;
   logic [AW-1:0]         wr_addr;
   logic [AW-1:0]         rd_addr;
   logic [CW-1:0]         count_in;
   pmq_pkg::status_type   status_in;
   pmq_pkg::dsel_type     dsel_in;

   // The block never holds a transaction off.
   assign busy   = 1'b0;
   assign accept = start && !busy;

   assign in_range = ({30'd0, req_payload.queue_id} < QUEUE_COUNT);
   assign qidx     = QW'(req_payload.queue_id);
   assign wr_cnt   = wr_cnt_ff[qidx];
   assign rd_cnt   = rd_cnt_ff[qidx];

   assign region_size = ({30'd0, req_payload.queue_id} == QUEUE_COUNT - 1)
                        ? CW'(LAST_SIZE) : CW'(REGION);
   assign base        = CW'(qidx) * CW'(REGION);

   assign is_full  = (wr_cnt >= region_size);
   assign is_empty = (rd_cnt >= wr_cnt);

   assign do_enq = accept && in_range && (req_payload.op == pmq_pkg::OP_ENQUEUE) && !is_full;
   assign do_deq = accept && in_range && (req_payload.op == pmq_pkg::OP_DEQUEUE) && !is_empty;

   assign wr_addr = AW'(base + wr_cnt);
   assign rd_addr = AW'(base + rd_cnt);

   always_comb begin
      status_in = pmq_pkg::ST_OK;
      dsel_in   = pmq_pkg::DSEL_ZERO;
      count_in  = '0;
      if (req_payload.op != pmq_pkg::OP_REINIT && in_range) begin
         case (req_payload.op)
            pmq_pkg::OP_ENQUEUE: begin
               if (is_full) begin
                  status_in = pmq_pkg::ST_FULL;
                  count_in  = wr_cnt - rd_cnt;
               end else begin
                  count_in = wr_cnt - rd_cnt + CW'(1);
               end
            end
            pmq_pkg::OP_DEQUEUE: begin
               if (is_empty) begin
                  status_in = pmq_pkg::ST_EMPTY;
                  dsel_in   = pmq_pkg::DSEL_EMPTY;
               end else begin
                  dsel_in  = pmq_pkg::DSEL_MEM;
                  count_in = wr_cnt - rd_cnt - CW'(1);
               end
            end
            default: begin
               count_in = wr_cnt - rd_cnt;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (do_enq) begin
         item_store[wr_addr] <= req_payload.value;
      end
      if (do_deq) begin
         rd_data_ff <= item_store[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
         for (int i = 0; i < QUEUE_COUNT; i++) begin
            wr_cnt_ff[i] <= '0;
            rd_cnt_ff[i] <= '0;
         end
      end else begin
         rsp_strobe_ff <= accept;
         if (accept && req_payload.op == pmq_pkg::OP_REINIT) begin
            for (int i = 0; i < QUEUE_COUNT; i++) begin
               wr_cnt_ff[i] <= '0;
               rd_cnt_ff[i] <= '0;
            end
         end else begin
            if (do_enq) begin
               wr_cnt_ff[qidx] <= wr_cnt + CW'(1);
            end
            if (do_deq) begin
               rd_cnt_ff[qidx] <= rd_cnt + CW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
         dsel_ff   <= dsel_in;
         count_ff  <= 8'(count_in);
      end
   end

   always_comb begin
      rsp_payload.status = status_ff;
      rsp_payload.count  = count_ff;
      case (dsel_ff)
         pmq_pkg::DSEL_MEM:   rsp_payload.data = rd_data_ff;
         pmq_pkg::DSEL_EMPTY: rsp_payload.data = pmq_pkg::EMPTY_DATA;
         default:             rsp_payload.data = '0;
      endcase
   end

   assign rsp_strobe = rsp_strobe_ff;

endmodule

`default_nettype wire

// ===== test/tb_partitioned_multi_queue_top.sv =====
`default_nettype none

module tb_partitioned_multi_queue_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MEMORY_DEPTH = 128;
   localparam int QUEUE_COUNT  = 3;
   localparam int REGION_WORDS = MEMORY_DEPTH / QUEUE_COUNT;
   localparam int STALL_LIMIT  = 2000;
   localparam int PHASE_ITEMS  = 400;

   typedef struct {
      pmq_pkg::req_type req;
      bit               pinned;
      pmq_pkg::rsp_type rsp;
   } stim_row_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   pmq_pkg::req_type req_payload = '0;
   logic             busy;
   logic             rsp_strobe;
   pmq_pkg::rsp_type rsp_payload;

   // A directed row may carry a typed-in answer that replaces the prediction.
   bit               pinned_valid = 1'b0;
   pmq_pkg::rsp_type pinned_rsp = '0;

   // Shadow of the block's queue state.
   logic signed [31:0] shadow_words [MEMORY_DEPTH];
   int                 fill_level [QUEUE_COUNT];
   int                 drain_level [QUEUE_COUNT];

   pmq_pkg::rsp_type awaiting [$];
   pmq_pkg::rsp_type predicted;
   pmq_pkg::rsp_type oldest;
   bit      progress;
   int      stall_cycles = 0;
   int      mismatches = 0;
   int      sent = 0;
   int      checked = 0;
   int      full_seen = 0;
   int      empty_seen = 0;
   int      reinit_seen = 0;
   int      idle_pct = 0;

   partitioned_multi_queue_top #(
      .MEMORY_DEPTH(MEMORY_DEPTH),
      .QUEUE_COUNT (QUEUE_COUNT)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_payload(req_payload),
      .rsp_strobe (rsp_strobe),
      .rsp_payload(rsp_payload)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic pmq_pkg::rsp_type apply_request(pmq_pkg::req_type r);
      pmq_pkg::rsp_type res;
      int      q;
      int      base;
      int      span;
      res = '{pmq_pkg::ST_OK, 32'sd0, 8'd0};
      q = r.queue_id;
      if (r.op == pmq_pkg::OP_REINIT) begin
         foreach (fill_level[i]) begin
            fill_level[i] = 0;
            drain_level[i] = 0;
         end
      end else if (q < QUEUE_COUNT) begin
         base = q * REGION_WORDS;
         span = (q == QUEUE_COUNT - 1) ? MEMORY_DEPTH - base : REGION_WORDS;
         case (r.op)
            pmq_pkg::OP_ENQUEUE: begin
               if (fill_level[q] >= span) begin
                  res.status = pmq_pkg::ST_FULL;
               end else begin
                  shadow_words[base + fill_level[q]] = r.value;
                  fill_level[q]++;
               end
            end
            pmq_pkg::OP_DEQUEUE: begin
               if (drain_level[q] >= fill_level[q]) begin
                  res.status = pmq_pkg::ST_EMPTY;
                  res.data = pmq_pkg::EMPTY_DATA;
               end else begin
                  res.data = shadow_words[base + drain_level[q]];
                  drain_level[q]++;
               end
            end
            default: ;
         endcase
         res.count = 8'(fill_level[q] - drain_level[q]);
      end
      return res;
   endfunction

   task automatic compare_result(pmq_pkg::rsp_type got);
      if (awaiting.size() == 0) begin
         $error("unexpected result: status %0d, data %0d, count %0d",
                got.status, got.data, got.count);
         mismatches++;
      end else begin
         oldest = awaiting.pop_front();
         checked++;
         if (got.status !== oldest.status) begin
            $error("status: expected %0d, actual %0d", oldest.status, got.status);
            mismatches++;
         end
         if (got.data !== oldest.data) begin
            $error("data: expected %0d, actual %0d", oldest.data, got.data);
            mismatches++;
         end
         if (got.count !== oldest.count) begin
            $error("count: expected %0d, actual %0d", oldest.count, got.count);
            mismatches++;
         end
         if (oldest.status == pmq_pkg::ST_FULL) full_seen++;
         if (oldest.status == pmq_pkg::ST_EMPTY) empty_seen++;
      end
   endtask

   // Outputs and inputs are read at the edge, before any update of that edge lands.
   always @(posedge clock) begin
      if (!reset) begin
         progress = 1'b0;
         if (rsp_strobe) begin
            progress = 1'b1;
            compare_result(rsp_payload);
         end
         if (start && !busy) begin
            progress = 1'b1;
            predicted = apply_request(req_payload);
            if (req_payload.op == pmq_pkg::OP_REINIT) reinit_seen++;
            awaiting.push_back(pinned_valid ? pinned_rsp : predicted);
         end
         stall_cycles = progress ? 0 : stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("** partitioned_multi_queue_top: FAILED **");
            $finish;
         end
      end
   end

   task automatic send(pmq_pkg::req_type r, bit pin, pmq_pkg::rsp_type pin_rsp);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_payload <= r;
      pinned_valid <= pin;
      pinned_rsp <= pin_rsp;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (r.op == pmq_pkg::OP_REINIT || r.queue_id < QUEUE_COUNT) sent++;
   endtask

   task automatic send_plain(pmq_pkg::op_type op, logic [1:0] qid,
                             logic signed [31:0] value);
      pmq_pkg::req_type r;
      r.op = op;
      r.queue_id = qid;
      r.value = value;
      send(r, 1'b0, '0);
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      @(posedge clock);
      while (awaiting.size() != 0) @(posedge clock);
   endtask

   function automatic logic signed [31:0] random_word();
      case ($urandom_range(9))
         0: return 32'sh7FFF_FFFF;
         1: return 32'sh8000_0000;
         2: return -32'sd1;
         3: return 32'sd0;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [1:0] random_queue();
      // Mostly real queues; now and then the unused id, which touches no queue, though a reinitialize still clears all.
      return ($urandom_range(99) < 8) ? 2'(QUEUE_COUNT) : 2'($urandom_range(QUEUE_COUNT - 1));
   endfunction

   task automatic run_phase(int pct, int items);
      int              target;
      int              pick;
      int              n;
      logic [1:0]      q;
      pmq_pkg::op_type op;
      idle_pct = pct;
      target = sent + items;
      while (sent < target) begin
         pick = $urandom_range(99);
         q = 2'($urandom_range(QUEUE_COUNT - 1));
         if (pick < 25) begin
            // Long enqueue runs push a queue into its full state.
            n = $urandom_range(10, 50);
            repeat (n) send_plain(pmq_pkg::OP_ENQUEUE, q, random_word());
         end else if (pick < 45) begin
            n = $urandom_range(5, 45);
            repeat (n) send_plain(pmq_pkg::OP_DEQUEUE, q, random_word());
         end else if (pick < 50) begin
            send_plain(pmq_pkg::OP_REINIT, 2'($urandom_range(3)), random_word());
         end else begin
            repeat (16) begin
               n = $urandom_range(99);
               op = (n < 42) ? pmq_pkg::OP_ENQUEUE : (n < 80) ? pmq_pkg::OP_DEQUEUE :
                    (n < 97) ? pmq_pkg::OP_SIZE : pmq_pkg::OP_REINIT;
               send_plain(op, random_queue(), random_word());
            end
         end
      end
   endtask

   stim_row_type directed_rows [23] = '{
      '{'{pmq_pkg::OP_SIZE,    2'd0, 32'sd0},         1'b1, '{pmq_pkg::ST_OK, 32'sd0, 8'd0}},
      '{'{pmq_pkg::OP_DEQUEUE, 2'd0, 32'sd0},         1'b1, '{pmq_pkg::ST_EMPTY, -32'sd1, 8'd0}},
      '{'{pmq_pkg::OP_DEQUEUE, 2'd2, 32'sd0},         1'b1, '{pmq_pkg::ST_EMPTY, -32'sd1, 8'd0}},
      '{'{pmq_pkg::OP_ENQUEUE, 2'd0, 32'sh7FFF_FFFF}, 1'b1, '{pmq_pkg::ST_OK, 32'sd0, 8'd1}},
      '{'{pmq_pkg::OP_ENQUEUE, 2'd0, 32'sh8000_0000}, 1'b1, '{pmq_pkg::ST_OK, 32'sd0, 8'd2}},
      '{'{pmq_pkg::OP_ENQUEUE, 2'd1, -32'sd1},        1'b1, '{pmq_pkg::ST_OK, 32'sd0, 8'd1}},
      '{'{pmq_pkg::OP_ENQUEUE, 2'd2, 32'sd0},         1'b1, '{pmq_pkg::ST_OK, 32'sd0, 8'd1}},
      '{'{pmq_pkg::OP_ENQUEUE, 2'd2, 32'sh5555_5555}, 1'b0, '0},
      '{'{pmq_pkg::OP_ENQUEUE, 2'd2, 32'shAAAA_AAAA}, 1'b0, '0},
      '{'{pmq_pkg::OP_SIZE,    2'd2, 32'sh1234_5678}, 1'b0, '0},
      '{'{pmq_pkg::OP_DEQUEUE, 2'd0, 32'sd0}, 1'b1, '{pmq_pkg::ST_OK, 32'sh7FFF_FFFF, 8'd1}},
      '{'{pmq_pkg::OP_DEQUEUE, 2'd0, 32'sd0}, 1'b1, '{pmq_pkg::ST_OK, 32'sh8000_0000, 8'd0}},
      '{'{pmq_pkg::OP_DEQUEUE, 2'd0, 32'sd0},         1'b1, '{pmq_pkg::ST_EMPTY, -32'sd1, 8'd0}},
      '{'{pmq_pkg::OP_ENQUEUE, 2'd3, 32'sh1234_5678}, 1'b1, '{pmq_pkg::ST_OK, 32'sd0, 8'd0}},
      '{'{pmq_pkg::OP_DEQUEUE, 2'd3, 32'sd0},         1'b1, '{pmq_pkg::ST_OK, 32'sd0, 8'd0}},
      '{'{pmq_pkg::OP_SIZE,    2'd3, 32'sd0},         1'b1, '{pmq_pkg::ST_OK, 32'sd0, 8'd0}},
      '{'{pmq_pkg::OP_DEQUEUE, 2'd2, 32'sd0},         1'b0, '0},
      '{'{pmq_pkg::OP_REINIT,  2'd3, -32'sd1},        1'b1, '{pmq_pkg::ST_OK, 32'sd0, 8'd0}},
      '{'{pmq_pkg::OP_SIZE,    2'd2, 32'sd0},         1'b1, '{pmq_pkg::ST_OK, 32'sd0, 8'd0}},
      '{'{pmq_pkg::OP_DEQUEUE, 2'd1, 32'sd0},         1'b1, '{pmq_pkg::ST_EMPTY, -32'sd1, 8'd0}},
      '{'{pmq_pkg::OP_ENQUEUE, 2'd1, 32'sd1},         1'b0, '0},
      '{'{pmq_pkg::OP_DEQUEUE, 2'd1, 32'sd0},         1'b0, '0},
      '{'{pmq_pkg::OP_REINIT,  2'd0, 32'sd0},         1'b1, '{pmq_pkg::ST_OK, 32'sd0, 8'd0}}
   };

   initial begin
      foreach (fill_level[i]) begin
         fill_level[i] = 0;
         drain_level[i] = 0;
      end
      foreach (shadow_words[i]) shadow_words[i] = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      idle_pct = 6;
      foreach (directed_rows[i]) begin
         send(directed_rows[i].req, directed_rows[i].pinned, directed_rows[i].rsp);
      end
      wait_drained();

      run_phase(6, PHASE_ITEMS);
      wait_drained();
      run_phase(62, PHASE_ITEMS);
      wait_drained();
      run_phase(0, PHASE_ITEMS);
      wait_drained();

      // Give a stray late result the chance to show up.
      repeat (4) @(posedge clock);
      if (awaiting.size() != 0) begin
         $error("%0d results never arrived", awaiting.size());
         mismatches++;
      end

      $display("Checked %0d results over %0d transactions in three sender idle profiles.",
               checked, sent);
      $display("Seen: %0d full refusals, %0d empty refusals, %0d reinitializations.",
               full_seen, empty_seen, reinit_seen);
      if (mismatches == 0) begin
         $display("** partitioned_multi_queue_top: PASSED **");
      end else begin
         $display("** partitioned_multi_queue_top: FAILED **");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/core/pmq_pkg.sv
rtl/core/partitioned_multi_queue_top.sv
test/tb_partitioned_multi_queue_top.sv
